/* rtl/core/matrix_power_mod_2x2_defines.svh */
// Assertion macros for the matrix power block checkers.
// Expects signals named clock and reset in the scope of use.
`ifndef MATRIX_POWER_MOD_2X2_DEFINES_SVH
`define MATRIX_POWER_MOD_2X2_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MPM_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MPM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/core/mpm_pkg.sv */
// Shared widths, register codes, reset values and unit interface structs
// for the 2x2 modular matrix power block. No dependencies.
package mpm_pkg;

   localparam int ENTRY_W          = 31;
   localparam int EXPONENT_W       = 63;
   localparam int EXP_BITS_DEFAULT = 63;
   localparam int REQ_DATA_W       = 64;
   localparam int RSP_DATA_W       = 128;
   localparam int RSP_PAD_W        = RSP_DATA_W - 4 * ENTRY_W;
   localparam int CSR_DATA_W       = 32;
   localparam int CSR_ADDR_W       = 5;
   localparam int REG_IDX_W        = 3;

   // Barrett datapath widths
   localparam int K_W    = 5;                 // bit length of modulus, up to 31
   localparam int MU_W   = ENTRY_W + 2;       // floor(2^2k / m) can reach 2^32
   localparam int PROD_W = 2 * MU_W;
   localparam int X_W    = 2 * ENTRY_W;       // a*b + c stays below 2^62
   localparam int R_W    = ENTRY_W + 2;       // residue before correction, < 3m

   // Serial divider
   localparam int DIV_NUM_W = 2 * ENTRY_W + 1; // holds 2^62
   localparam int DIV_CNT_W = $clog2(DIV_NUM_W);

   // Register indexes
   localparam logic [REG_IDX_W-1:0] REG_ENTRY_00 = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_ENTRY_01 = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_ENTRY_10 = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_ENTRY_11 = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_MODULUS  = 3'd4;

   localparam logic [ENTRY_W-1:0] ENTRY_00_RESET = 31'd19;
   localparam logic [ENTRY_W-1:0] ENTRY_01_RESET = 31'd6;
   localparam logic [ENTRY_W-1:0] ENTRY_10_RESET = 31'd7;
   localparam logic [ENTRY_W-1:0] ENTRY_11_RESET = 31'd20;
   localparam logic [ENTRY_W-1:0] MODULUS_RESET  = 31'd1000000007;

   typedef struct packed {
      logic               start;
      logic [ENTRY_W-1:0] a;
      logic [ENTRY_W-1:0] b;
      logic [ENTRY_W-1:0] c;
   } mm_req_type;

   typedef struct packed {
      logic [ENTRY_W-1:0] m;
      logic [MU_W-1:0]    mu;
      logic [K_W-1:0]     k;
   } mm_cfg_type;

   typedef struct packed {
      logic               done;
      logic [ENTRY_W-1:0] res;
   } mm_rsp_type;

   typedef struct packed {
      logic                 start;
      logic [DIV_NUM_W-1:0] num;
      logic [ENTRY_W-1:0]   den;
   } div_req_type;

   typedef struct packed {
      logic                 done;
      logic [DIV_NUM_W-1:0] quo;
      logic [ENTRY_W-1:0]   rem;
   } div_rsp_type;

endpackage

/* rtl/core/mpm_div.sv */
// Restoring divider, one quotient bit per cycle, for reciprocal and base
// entry reduction. Depends on mpm_pkg.
module mpm_div (
   input  logic                 clock,
   input  logic                 reset,
   input  mpm_pkg::div_req_type req,
   output mpm_pkg::div_rsp_type rsp
);

   typedef enum logic [1:0] {
      D_IDLE,
      D_RUN,
      D_DONE
   } div_state_type;

   div_state_type                    state_ff, state_in;
   logic [mpm_pkg::DIV_CNT_W-1:0]    cnt_ff, cnt_in;
   logic [mpm_pkg::DIV_NUM_W-1:0]    num_ff, num_in;
   logic [mpm_pkg::DIV_NUM_W-1:0]    quo_ff, quo_in;
   logic [mpm_pkg::ENTRY_W-1:0]      rem_ff, rem_in;
   logic [mpm_pkg::ENTRY_W-1:0]      den_ff, den_in;

   logic [mpm_pkg::ENTRY_W:0]        rem_try;
   logic [mpm_pkg::ENTRY_W:0]        rem_diff;
   logic                             fits;

   assign rem_try  = {rem_ff, num_ff[mpm_pkg::DIV_NUM_W-1]};
   assign rem_diff = rem_try - {1'b0, den_ff};
   assign fits     = rem_try >= {1'b0, den_ff};

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      num_in   = num_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      unique case (state_ff)
         D_IDLE: begin
            if (req.start) begin
               num_in   = req.num;
               den_in   = req.den;
               rem_in   = '0;
               quo_in   = '0;
               cnt_in   = mpm_pkg::DIV_CNT_W'(mpm_pkg::DIV_NUM_W - 1);
               state_in = D_RUN;
            end
         end
         D_RUN: begin
            num_in = num_ff << 1;
            quo_in = {quo_ff[mpm_pkg::DIV_NUM_W-2:0], fits};
            rem_in = fits ? rem_diff[mpm_pkg::ENTRY_W-1:0] : rem_try[mpm_pkg::ENTRY_W-1:0];
            if (cnt_ff == '0) begin
               state_in = D_DONE;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         D_DONE: begin
            state_in = D_IDLE;
         end
         default: begin
            state_in = D_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
      end else begin
         state_ff <= state_in;
      end
      cnt_ff <= cnt_in;
      num_ff <= num_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign rsp.done = (state_ff == D_DONE);
   assign rsp.quo  = quo_ff;
   assign rsp.rem  = rem_ff;

endmodule

/* rtl/core/mpm_modmul.sv */
// Modular multiply-accumulate (a*b + c) mod m by Barrett reduction on one
// shared 33x33 multiplier, one request at a time. Depends on mpm_pkg.
module mpm_modmul (
   input  logic                clock,
   input  logic                reset,
   input  mpm_pkg::mm_cfg_type cfg,
   input  mpm_pkg::mm_req_type req,
   output mpm_pkg::mm_rsp_type rsp
);

   typedef enum logic [3:0] {
      M_IDLE,
      M_MUL1,
      M_ADD,
      M_MUL2,
      M_SHQ,
      M_MUL3,
      M_SUB,
      M_FIX1,
      M_FIX2,
      M_DONE
   } mm_state_type;

   mm_state_type                   state_ff, state_in;
   logic [mpm_pkg::ENTRY_W-1:0]    a_ff, a_in;
   logic [mpm_pkg::ENTRY_W-1:0]    b_ff, b_in;
   logic [mpm_pkg::ENTRY_W-1:0]    c_ff, c_in;
   logic [mpm_pkg::PROD_W-1:0]     prod_ff, prod_in;
   logic [mpm_pkg::X_W-1:0]        x_ff, x_in;
   logic [mpm_pkg::ENTRY_W-1:0]    q_ff, q_in;
   logic [mpm_pkg::R_W-1:0]        r_ff, r_in;

   logic [mpm_pkg::MU_W-1:0]       mul_a;
   logic [mpm_pkg::MU_W-1:0]       mul_b;
   logic [mpm_pkg::PROD_W-1:0]     mul_p;
   logic [mpm_pkg::K_W-1:0]        sh_lo;
   logic [mpm_pkg::K_W:0]          sh_hi;
   logic [mpm_pkg::X_W-1:0]        x_shift;
   logic [mpm_pkg::PROD_W-1:0]     q_shift;
   logic [mpm_pkg::R_W-1:0]        m_ext;

   assign sh_lo   = cfg.k - 1'b1;
   assign sh_hi   = {1'b0, cfg.k} + 1'b1;
   assign x_shift = x_ff >> sh_lo;
   assign q_shift = prod_ff >> sh_hi;
   assign m_ext   = mpm_pkg::R_W'(cfg.m);

   // Shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         M_MUL1: begin
            mul_a = mpm_pkg::MU_W'(a_ff);
            mul_b = mpm_pkg::MU_W'(b_ff);
         end
         M_MUL2: begin
            mul_a = x_shift[mpm_pkg::MU_W-1:0];
            mul_b = cfg.mu;
         end
         M_MUL3: begin
            mul_a = mpm_pkg::MU_W'(q_ff);
            mul_b = mpm_pkg::MU_W'(cfg.m);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = mpm_pkg::PROD_W'(mul_a) * mpm_pkg::PROD_W'(mul_b);

   always_comb begin
      state_in = state_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      c_in     = c_ff;
      prod_in  = prod_ff;
      x_in     = x_ff;
      q_in     = q_ff;
      r_in     = r_ff;
      unique case (state_ff)
         M_IDLE: begin
            if (req.start) begin
               a_in     = req.a;
               b_in     = req.b;
               c_in     = req.c;
               state_in = M_MUL1;
            end
         end
         M_MUL1: begin
            prod_in  = mul_p;
            state_in = M_ADD;
         end
         M_ADD: begin
            x_in     = prod_ff[mpm_pkg::X_W-1:0] + mpm_pkg::X_W'(c_ff);
            state_in = M_MUL2;
         end
         M_MUL2: begin
            prod_in  = mul_p;
            state_in = M_SHQ;
         end
         M_SHQ: begin
            q_in     = q_shift[mpm_pkg::ENTRY_W-1:0];
            state_in = M_MUL3;
         end
         M_MUL3: begin
            prod_in  = mul_p;
            state_in = M_SUB;
         end
         M_SUB: begin
            // residue is below 3m, so the low bits are exact
            r_in     = x_ff[mpm_pkg::R_W-1:0] - prod_ff[mpm_pkg::R_W-1:0];
            state_in = M_FIX1;
         end
         M_FIX1: begin
            if (r_ff >= m_ext) begin
               r_in = r_ff - m_ext;
            end
            state_in = M_FIX2;
         end
         M_FIX2: begin
            if (r_ff >= m_ext) begin
               r_in = r_ff - m_ext;
            end
            state_in = M_DONE;
         end
         M_DONE: begin
            state_in = M_IDLE;
         end
         default: begin
            state_in = M_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= M_IDLE;
      end else begin
         state_ff <= state_in;
      end
      a_ff    <= a_in;
      b_ff    <= b_in;
      c_ff    <= c_in;
      prod_ff <= prod_in;
      x_ff    <= x_in;
      q_ff    <= q_in;
      r_ff    <= r_in;
   end

   assign rsp.done = (state_ff == M_DONE);
   assign rsp.res  = r_ff[mpm_pkg::ENTRY_W-1:0];

endmodule

/* rtl/core/matrix_power_mod_2x2.sv */
// Raises the configured 2x2 base matrix to the power in each request word,
// modulo the configured modulus. Depends on mpm_pkg, mpm_div, mpm_modmul.
//
// Use:
//   Write entry_00..entry_11 and modulus over the csr_ APB port (byte address
//   4*index) while the block is idle. Send one exponent per req_ word; one
//   rsp_ word returns the four entries of the power.
//   req_tready is high only while the sequencer waits for a word; one word is
//   worked on at a time.
// Work per request word:
//   one matrix product per exponent bit, squaring, and one more per set
//   exponent bit, multiplying by the base; a zero modulus returns zeros with
//   no product. Each matrix product is eight multiply-accumulates on the
//   single Barrett unit; ahead of the products come the bit-length scan and
//   five 63-step serial divisions (reciprocal of the modulus and reduction
//   of the four base entries).
// Reset restores the default base matrix and modulus and drops any word in
// flight. A stalled receiver holds the result in the output register; a new
// request may be accepted meanwhile and finishes into that register once it
// is free.
module matrix_power_mod_2x2 #(
   parameter int EXP_BITS = mpm_pkg::EXP_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   // req_tdata: [62:0] exponent, [63] zero
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [mpm_pkg::REQ_DATA_W-1:0]    req_tdata,
   // rsp_tdata: [30:0] power_00, [61:31] power_01, [92:62] power_10,
   //            [123:93] power_11, [127:124] zero
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [mpm_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [mpm_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [mpm_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [mpm_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);

   localparam int USE_BITS = (EXP_BITS < mpm_pkg::EXPONENT_W) ? EXP_BITS
                                                              : mpm_pkg::EXPONENT_W;
   localparam int BIT_W    = (USE_BITS > 1) ? $clog2(USE_BITS) : 1;

   typedef enum logic [3:0] {
      S_IDLE,
      S_LEN,
      S_MU_GO,
      S_MU_WAIT,
      S_BASE_GO,
      S_BASE_WAIT,
      S_MAT_START,
      S_MM_GO,
      S_MM_WAIT,
      S_MAT_END,
      S_DONE
   } top_state_type;

   // Configuration registers
   logic [mpm_pkg::ENTRY_W-1:0]    entry_00_ff, entry_00_in;
   logic [mpm_pkg::ENTRY_W-1:0]    entry_01_ff, entry_01_in;
   logic [mpm_pkg::ENTRY_W-1:0]    entry_10_ff, entry_10_in;
   logic [mpm_pkg::ENTRY_W-1:0]    entry_11_ff, entry_11_in;
   logic [mpm_pkg::ENTRY_W-1:0]    modulus_ff, modulus_in;

   // Sequencer
   top_state_type                  state_ff, state_in;
   logic [USE_BITS-1:0]            exp_ff, exp_in;
   logic [BIT_W-1:0]               bit_ff, bit_in;
   logic                           mult_ff, mult_in;
   logic [1:0]                     ent_ff, ent_in;
   logic                           term_ff, term_in;
   logic [mpm_pkg::K_W-1:0]        len_ff, len_in;
   logic [mpm_pkg::ENTRY_W-1:0]    scan_ff, scan_in;
   logic [mpm_pkg::MU_W-1:0]       mu_ff, mu_in;
   logic [mpm_pkg::ENTRY_W-1:0]    part_ff, part_in;
   logic [mpm_pkg::ENTRY_W-1:0]    base_ff [4];
   logic [mpm_pkg::ENTRY_W-1:0]    base_in [4];
   logic [mpm_pkg::ENTRY_W-1:0]    acc_ff  [4];
   logic [mpm_pkg::ENTRY_W-1:0]    acc_in  [4];
   logic [mpm_pkg::ENTRY_W-1:0]    yop_ff  [4];
   logic [mpm_pkg::ENTRY_W-1:0]    yop_in  [4];
   logic [mpm_pkg::ENTRY_W-1:0]    new_ff  [4];
   logic [mpm_pkg::ENTRY_W-1:0]    new_in  [4];
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [mpm_pkg::ENTRY_W-1:0]    rsp_data_ff [4];
   logic [mpm_pkg::ENTRY_W-1:0]    rsp_data_in [4];

   logic                           csr_wr;
   logic [mpm_pkg::REG_IDX_W-1:0]  csr_idx;
   logic [mpm_pkg::ENTRY_W-1:0]    entry_sel;
   logic [mpm_pkg::ENTRY_W-1:0]    one_mod;
   logic                           req_fire;

   mpm_pkg::mm_cfg_type            mm_cfg;
   mpm_pkg::mm_req_type            mm_req;
   mpm_pkg::mm_rsp_type            mm_rsp;
   mpm_pkg::div_req_type           div_req;
   mpm_pkg::div_rsp_type           div_rsp;

   mpm_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   mpm_modmul u_modmul (
      .clock (clock),
      .reset (reset),
      .cfg   (mm_cfg),
      .req   (mm_req),
      .rsp   (mm_rsp)
   );

   // ---------------- Configuration port ----------------
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;
   assign csr_idx    = csr_paddr[mpm_pkg::CSR_ADDR_W-1:2];

   always_comb begin
      entry_00_in = entry_00_ff;
      entry_01_in = entry_01_ff;
      entry_10_in = entry_10_ff;
      entry_11_in = entry_11_ff;
      modulus_in  = modulus_ff;
      if (csr_wr) begin
         unique case (csr_idx)
            mpm_pkg::REG_ENTRY_00: entry_00_in = csr_pwdata[mpm_pkg::ENTRY_W-1:0];
            mpm_pkg::REG_ENTRY_01: entry_01_in = csr_pwdata[mpm_pkg::ENTRY_W-1:0];
            mpm_pkg::REG_ENTRY_10: entry_10_in = csr_pwdata[mpm_pkg::ENTRY_W-1:0];
            mpm_pkg::REG_ENTRY_11: entry_11_in = csr_pwdata[mpm_pkg::ENTRY_W-1:0];
            mpm_pkg::REG_MODULUS:  modulus_in  = csr_pwdata[mpm_pkg::ENTRY_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         mpm_pkg::REG_ENTRY_00: csr_prdata = mpm_pkg::CSR_DATA_W'(entry_00_ff);
         mpm_pkg::REG_ENTRY_01: csr_prdata = mpm_pkg::CSR_DATA_W'(entry_01_ff);
         mpm_pkg::REG_ENTRY_10: csr_prdata = mpm_pkg::CSR_DATA_W'(entry_10_ff);
         mpm_pkg::REG_ENTRY_11: csr_prdata = mpm_pkg::CSR_DATA_W'(entry_11_ff);
         mpm_pkg::REG_MODULUS:  csr_prdata = mpm_pkg::CSR_DATA_W'(modulus_ff);
         default:               csr_prdata = '0;
      endcase
   end

   // ---------------- Unit requests ----------------
   always_comb begin
      case (ent_ff)
         2'd0:    entry_sel = entry_00_ff;
         2'd1:    entry_sel = entry_01_ff;
         2'd2:    entry_sel = entry_10_ff;
         default: entry_sel = entry_11_ff;
      endcase
   end

   assign one_mod = (modulus_ff == mpm_pkg::ENTRY_W'(1)) ? '0 : mpm_pkg::ENTRY_W'(1);

   assign mm_cfg.m  = modulus_ff;
   assign mm_cfg.mu = mu_ff;
   assign mm_cfg.k  = len_ff;

   // Entry (i,j) term t multiplies acc[i][t] by y[t][j]
   assign mm_req.start = (state_ff == S_MM_GO);
   assign mm_req.a     = acc_ff[{ent_ff[1], term_ff}];
   assign mm_req.b     = yop_ff[{term_ff, ent_ff[0]}];
   assign mm_req.c     = term_ff ? part_ff : '0;

   always_comb begin
      div_req.start = 1'b0;
      div_req.den   = modulus_ff;
      div_req.num   = mpm_pkg::DIV_NUM_W'(entry_sel);
      if (state_ff == S_MU_GO) begin
         div_req.start = 1'b1;
         div_req.num   = mpm_pkg::DIV_NUM_W'(1) << {len_ff, 1'b0};
      end else if (state_ff == S_BASE_GO) begin
         div_req.start = 1'b1;
      end
   end

   // ---------------- Sequencer ----------------
   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid & req_tready;

   always_comb begin
      state_in     = state_ff;
      exp_in       = exp_ff;
      bit_in       = bit_ff;
      mult_in      = mult_ff;
      ent_in       = ent_ff;
      term_in      = term_ff;
      len_in       = len_ff;
      scan_in      = scan_ff;
      mu_in        = mu_ff;
      part_in      = part_ff;
      base_in      = base_ff;
      acc_in       = acc_ff;
      yop_in       = yop_ff;
      new_in       = new_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               exp_in = req_tdata[USE_BITS-1:0];
               if (modulus_ff == '0) begin
                  for (int i = 0; i < 4; i++) begin
                     acc_in[i] = '0;
                  end
                  state_in = S_DONE;
               end else begin
                  scan_in  = modulus_ff;
                  len_in   = '0;
                  state_in = S_LEN;
               end
            end
         end
         S_LEN: begin
            // count the bit length of the modulus
            if (scan_ff == '0) begin
               state_in = S_MU_GO;
            end else begin
               scan_in = scan_ff >> 1;
               len_in  = len_ff + 1'b1;
            end
         end
         S_MU_GO: begin
            state_in = S_MU_WAIT;
         end
         S_MU_WAIT: begin
            if (div_rsp.done) begin
               mu_in    = div_rsp.quo[mpm_pkg::MU_W-1:0];
               ent_in   = '0;
               state_in = S_BASE_GO;
            end
         end
         S_BASE_GO: begin
            state_in = S_BASE_WAIT;
         end
         S_BASE_WAIT: begin
            if (div_rsp.done) begin
               base_in[ent_ff] = div_rsp.rem;
               if (ent_ff == 2'd3) begin
                  acc_in[0] = one_mod;
                  acc_in[1] = '0;
                  acc_in[2] = '0;
                  acc_in[3] = one_mod;
                  bit_in    = BIT_W'(USE_BITS - 1);
                  mult_in   = 1'b0;
                  state_in  = S_MAT_START;
               end else begin
                  ent_in   = ent_ff + 1'b1;
                  state_in = S_BASE_GO;
               end
            end
         end
         S_MAT_START: begin
            // snapshot the right-hand operand: acc for a squaring, base otherwise
            for (int i = 0; i < 4; i++) begin
               yop_in[i] = mult_ff ? base_ff[i] : acc_ff[i];
            end
            ent_in   = '0;
            term_in  = 1'b0;
            state_in = S_MM_GO;
         end
         S_MM_GO: begin
            state_in = S_MM_WAIT;
         end
         S_MM_WAIT: begin
            if (mm_rsp.done) begin
               if (!term_ff) begin
                  part_in  = mm_rsp.res;
                  term_in  = 1'b1;
                  state_in = S_MM_GO;
               end else begin
                  new_in[ent_ff] = mm_rsp.res;
                  term_in        = 1'b0;
                  if (ent_ff == 2'd3) begin
                     state_in = S_MAT_END;
                  end else begin
                     ent_in   = ent_ff + 1'b1;
                     state_in = S_MM_GO;
                  end
               end
            end
         end
         S_MAT_END: begin
            acc_in = new_ff;
            if (!mult_ff && exp_ff[bit_ff]) begin
               mult_in  = 1'b1;
               state_in = S_MAT_START;
            end else if (bit_ff == '0) begin
               state_in = S_DONE;
            end else begin
               bit_in   = bit_ff - 1'b1;
               mult_in  = 1'b0;
               state_in = S_MAT_START;
            end
         end
         S_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_data_in  = acc_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         entry_00_ff  <= mpm_pkg::ENTRY_00_RESET;
         entry_01_ff  <= mpm_pkg::ENTRY_01_RESET;
         entry_10_ff  <= mpm_pkg::ENTRY_10_RESET;
         entry_11_ff  <= mpm_pkg::ENTRY_11_RESET;
         modulus_ff   <= mpm_pkg::MODULUS_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         entry_00_ff  <= entry_00_in;
         entry_01_ff  <= entry_01_in;
         entry_10_ff  <= entry_10_in;
         entry_11_ff  <= entry_11_in;
         modulus_ff   <= modulus_in;
      end
      exp_ff      <= exp_in;
      bit_ff      <= bit_in;
      mult_ff     <= mult_in;
      ent_ff      <= ent_in;
      term_ff     <= term_in;
      len_ff      <= len_in;
      scan_ff     <= scan_in;
      mu_ff       <= mu_in;
      part_ff     <= part_in;
      base_ff     <= base_in;
      acc_ff      <= acc_in;
      yop_ff      <= yop_in;
      new_ff      <= new_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{mpm_pkg::RSP_PAD_W{1'b0}}, rsp_data_ff[3], rsp_data_ff[2],
                        rsp_data_ff[1], rsp_data_ff[0]};

endmodule

/* rtl/core/mpm_checker.sv */
// Port-level checker for matrix_power_mod_2x2, bound to the top level.
// Depends on mpm_pkg and matrix_power_mod_2x2_defines.svh.
`include "matrix_power_mod_2x2_defines.svh"

module mpm_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [mpm_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   `MPM_ASSERT_NEXT(a_rsp_valid_hold, rsp_tvalid && !rsp_tready, rsp_tvalid, "rsp word dropped while stalled")
   `MPM_ASSERT_NEXT(a_rsp_data_hold, rsp_tvalid && !rsp_tready, $stable(rsp_tdata), "rsp word changed while stalled")
   `MPM_ASSERT_NEXT(a_req_busy, req_tvalid && req_tready, !req_tready, "req accepted while a word is in work")
   `MPM_ASSERT_SAME(a_rsp_pad_zero, rsp_tvalid, rsp_tdata[mpm_pkg::RSP_DATA_W-1:4*mpm_pkg::ENTRY_W] == '0, "rsp pad bits not zero")

endmodule

bind matrix_power_mod_2x2 mpm_checker u_mpm_checker (.*);

/* tb/testbench.sv */
// Self-checking bench for matrix_power_mod_2x2: exponents in, matrix powers out,
// every word predicted by square-and-multiply and compared field by field.
// Depends on mpm_pkg and the matrix_power_mod_2x2 RTL.
`timescale 1ns / 100ps

module testbench;

   typedef struct packed {
      bit [63:0] e00;
      bit [63:0] e01;
      bit [63:0] e10;
      bit [63:0] e11;
   } mat_type;

   // Field order matches rsp_tdata: power_00 in the lowest bits.
   typedef struct packed {
      bit [mpm_pkg::ENTRY_W-1:0] p11;
      bit [mpm_pkg::ENTRY_W-1:0] p10;
      bit [mpm_pkg::ENTRY_W-1:0] p01;
      bit [mpm_pkg::ENTRY_W-1:0] p00;
   } power_type;

   class matrix_power_tracker_type;
      bit [mpm_pkg::ENTRY_W-1:0] entry_reg [4] = '{mpm_pkg::ENTRY_00_RESET,
                                                   mpm_pkg::ENTRY_01_RESET,
                                                   mpm_pkg::ENTRY_10_RESET,
                                                   mpm_pkg::ENTRY_11_RESET};
      bit [mpm_pkg::ENTRY_W-1:0] modulus_reg = mpm_pkg::MODULUS_RESET;
      power_type                 expected_powers [$];
      int                        errors;
      int                        checked;

      function void set_register(logic [mpm_pkg::REG_IDX_W-1:0] idx, logic [31:0] value);
         case (idx)
            mpm_pkg::REG_ENTRY_00: entry_reg[0] = value[mpm_pkg::ENTRY_W-1:0];
            mpm_pkg::REG_ENTRY_01: entry_reg[1] = value[mpm_pkg::ENTRY_W-1:0];
            mpm_pkg::REG_ENTRY_10: entry_reg[2] = value[mpm_pkg::ENTRY_W-1:0];
            mpm_pkg::REG_ENTRY_11: entry_reg[3] = value[mpm_pkg::ENTRY_W-1:0];
            mpm_pkg::REG_MODULUS:  modulus_reg = value[mpm_pkg::ENTRY_W-1:0];
            default: ;
         endcase
      endfunction

      // Reduce after the first product, then after adding the second.
      function bit [63:0] dot_mod(bit [63:0] a, bit [63:0] b, bit [63:0] c,
                                  bit [63:0] d, bit [63:0] m);
         return ((a * b) % m + c * d) % m;
      endfunction

      function mat_type mat_product(mat_type x, mat_type y, bit [63:0] m);
         mat_type r;
         r.e00 = dot_mod(x.e00, y.e00, x.e01, y.e10, m);
         r.e01 = dot_mod(x.e00, y.e01, x.e01, y.e11, m);
         r.e10 = dot_mod(x.e10, y.e00, x.e11, y.e10, m);
         r.e11 = dot_mod(x.e10, y.e01, x.e11, y.e11, m);
         return r;
      endfunction

      function void note_exponent(bit [mpm_pkg::EXPONENT_W-1:0] exponent);
         mat_type   base;
         mat_type   acc;
         power_type p;
         bit [63:0] m;
         int        b;
         m = 64'(modulus_reg);
         p = '0;
         if (m != 0) begin
            base.e00 = 64'(entry_reg[0]) % m;
            base.e01 = 64'(entry_reg[1]) % m;
            base.e10 = 64'(entry_reg[2]) % m;
            base.e11 = 64'(entry_reg[3]) % m;
            acc = '0;
            acc.e00 = 64'd1 % m;
            acc.e11 = 64'd1 % m;
            for (b = mpm_pkg::EXP_BITS_DEFAULT - 1; b >= 0; b--) begin
               acc = mat_product(acc, acc, m);
               if (exponent[b]) acc = mat_product(acc, base, m);
            end
            p.p00 = acc.e00[mpm_pkg::ENTRY_W-1:0];
            p.p01 = acc.e01[mpm_pkg::ENTRY_W-1:0];
            p.p10 = acc.e10[mpm_pkg::ENTRY_W-1:0];
            p.p11 = acc.e11[mpm_pkg::ENTRY_W-1:0];
         end
         expected_powers = {expected_powers, p};
      endfunction

      function void compare_field(string name, bit [mpm_pkg::ENTRY_W-1:0] want,
                                  bit [mpm_pkg::ENTRY_W-1:0] got);
         if (want != got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         end
      endfunction

      function void check_power(logic [mpm_pkg::RSP_DATA_W-1:0] word);
         power_type want;
         power_type got;
         got = power_type'(word[4*mpm_pkg::ENTRY_W-1:0]);
         checked++;
         if (expected_powers.size() == 0) begin
            errors++;
            $display("%0t: unexpected result word, expected none, actual %h", $time, word);
         end else begin
            want = expected_powers.pop_front();
            compare_field("power_00", want.p00, got.p00);
            compare_field("power_01", want.p01, got.p01);
            compare_field("power_10", want.p10, got.p10);
            compare_field("power_11", want.p11, got.p11);
         end
      endfunction

      function int pending();
         return expected_powers.size();
      endfunction
   endclass

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [mpm_pkg::REQ_DATA_W-1:0] req_tdata = '0;   // [62:0] exponent, [63] zero
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   // power_00, power_01, power_10, power_11
   logic [mpm_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                           csr_psel = 1'b0;
   logic                           csr_penable = 1'b0;
   logic                           csr_pwrite = 1'b0;
   logic [mpm_pkg::CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [mpm_pkg::CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [mpm_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                           csr_pready;

   matrix_power_tracker_type tracker = new;
   bit                       steady = 1'b0;
   int                       exponents_sent = 0;
   int                       settings_used = 0;

   matrix_power_mod_2x2 dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Drop valid and hold until every predicted word has come back.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
   endtask

   task automatic write_register(logic [mpm_pkg::REG_IDX_W-1:0] idx, logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      tracker.set_register(idx, value);
      @(posedge clock);
   endtask

   task automatic apply_setting(logic [31:0] e00, logic [31:0] e01, logic [31:0] e10,
                                logic [31:0] e11, logic [31:0] m);
      drain_results();
      write_register(mpm_pkg::REG_ENTRY_00, e00);
      write_register(mpm_pkg::REG_ENTRY_01, e01);
      write_register(mpm_pkg::REG_ENTRY_10, e10);
      write_register(mpm_pkg::REG_ENTRY_11, e11);
      write_register(mpm_pkg::REG_MODULUS, m);
      settings_used++;
   endtask

   // Leave valid high on return so back-to-back words need no extra edge.
   task automatic send_exponent(bit [mpm_pkg::EXPONENT_W-1:0] exponent);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, exponent};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      tracker.note_exponent(exponent);
      exponents_sent++;
   endtask

   function automatic bit [mpm_pkg::EXPONENT_W-1:0] draw_exponent();
      bit [63:0] wide;
      wide = {$urandom, $urandom};
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return wide[mpm_pkg::EXPONENT_W-1:0];
         4, 5:       return mpm_pkg::EXPONENT_W'($urandom_range(0, 1023));
         6:          return 63'd1 << $urandom_range(0, mpm_pkg::EXPONENT_W - 1);
         7:          return {mpm_pkg::EXPONENT_W{1'b1}} >>
                            $urandom_range(0, mpm_pkg::EXPONENT_W - 1);
         8:          return '0;
         default:    return mpm_pkg::EXPONENT_W'($urandom);
      endcase
   endfunction

   function automatic logic [31:0] draw_modulus();
      case ($urandom_range(0, 9))
         0, 1:    return $urandom_range(2, 100);
         2:       return 32'h7FFF_FFFF;
         3:       return $urandom_range(32'h4000_0000, 32'h7FFF_FFFF);
         4:       return $urandom_range(0, 1);
         default: return $urandom_range(2, 32'h7FFF_FFFF);
      endcase
   endfunction

   // Mix raw 31-bit entries with ones already below the modulus.
   function automatic logic [31:0] draw_entry(logic [31:0] m);
      logic [31:0] v;
      if ($urandom_range(0, 1) == 0 || m[30:0] < 2) v = $urandom_range(0, 32'h7FFF_FFFF);
      else v = $urandom_range(0, m[30:0] - 1);
      return {$urandom_range(0, 1) == 1, v[30:0]};
   endfunction

   // Result side: either ready up front, or wait for valid and stall on it.
   initial begin
      int stall;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = steady ? 0 : $urandom_range(0, 12);
         if (stall == 0) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b0;
            @(posedge clock);
            while (!rsp_tvalid) @(posedge clock);
            repeat (stall - 1) @(posedge clock);
            rsp_tready <= 1'b1;
         end
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         tracker.check_power(rsp_tdata);
      end
   end

   initial begin
      bit [mpm_pkg::EXPONENT_W-1:0] ones;
      logic [31:0]                  m;
      logic [31:0]                  m_draw;
      int                           phase;
      int                           n;
      ones = '1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset base matrix: edges of the exponent and alternating bit patterns.
      send_exponent('0);
      send_exponent(63'd1);
      send_exponent(63'd2);
      send_exponent(63'd3);
      send_exponent(63'd10);
      send_exponent(ones);
      send_exponent(63'h4000_0000_0000_0000);
      send_exponent(63'h5555_5555_5555_5555);
      send_exponent(63'h2AAA_AAAA_AAAA_AAAA);

      // Largest modulus, entries at it and below it.
      apply_setting(32'h7FFF_FFFE, 32'h7FFF_FFFF, 32'hFFFF_FFFE, 32'h0001_2345,
                    32'h7FFF_FFFF);
      send_exponent('0);
      send_exponent(ones);
      send_exponent(63'h1234_5678_9ABC_DEF0);

      // Modulus one: everything collapses to zero.
      apply_setting(32'd3, 32'd4, 32'd5, 32'd6, 32'd1);
      send_exponent('0);
      send_exponent(63'd5);

      // Modulus zero: zero result without reduction.
      apply_setting(32'd3, 32'd4, 32'd5, 32'd6, 32'd0);
      send_exponent('0);
      send_exponent(ones);

      // Fibonacci matrix mod two, with the unused top write bit set.
      apply_setting(32'd1, 32'd1, 32'd1, 32'd0, 32'h8000_0002);
      send_exponent('0);
      send_exponent(63'd7);

      apply_setting(32'd100, 32'd0, 32'd5, 32'h7FFF_FFFF, 32'd3);
      send_exponent(63'd12345);

      for (phase = 0; phase < 8; phase++) begin
         m_draw = draw_modulus();
         m = {$urandom_range(0, 1) == 1, m_draw[30:0]};
         apply_setting(draw_entry(m), draw_entry(m), draw_entry(m), draw_entry(m), m);
         steady = (phase == 3);
         for (n = 0; n < 50; n++) begin
            if (n == 25) drain_results();
            send_exponent(draw_exponent());
         end
      end
      steady = 1'b0;

      drain_results();
      // Catch any stray word well past the longest compute time.
      repeat (12000) @(posedge clock);
      $display("Sent %0d exponents under %0d register settings", exponents_sent,
               settings_used + 1);
      $display("(moduli zero, one, small, full width); compared %0d result words.",
               tracker.checked);
      if (tracker.errors == 0 && tracker.pending() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #250_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/mpm_pkg.sv
rtl/core/mpm_div.sv
rtl/core/mpm_modmul.sv
rtl/core/matrix_power_mod_2x2.sv
rtl/core/mpm_checker.sv
tb/testbench.sv
